@@ rtl/pe_pkg.sv @@
package pe_pkg;

  localparam int VALUE_WIDTH   = 24;
  localparam int TIME_WIDTH    = 16;
  localparam int FRACTION_BITS = 16;

  // Normalized time and curve values lie in [0, 2^F] and need one extra bit.
  localparam int UW = FRACTION_BITS + 1;
  // Dividend of the time normalization: (t << F) + (d >> 1).
  localparam int NW = TIME_WIDTH + FRACTION_BITS + 1;
  // Signed product of the value span and the curve value.
  localparam int PW = VALUE_WIDTH + UW + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH;

  localparam logic [UW-1:0] ONE_Q  = UW'(1) << FRACTION_BITS;
  localparam logic [UW-1:0] HALF_Q = UW'(1) << (FRACTION_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER     = 3'd0,
    REG_DIRECTION = 3'd1,
    REG_DURATION  = 3'd2,
    REG_START     = 3'd3,
    REG_END       = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_IN    = 2'd0,
    DIR_OUT   = 2'd1,
    DIR_INOUT = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_IO_LO = 2'd2,
    MODE_IO_HI = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]             power;
    logic [1:0]             direction;
    logic [TIME_WIDTH-1:0]  duration;
    logic [VALUE_WIDTH-1:0] start_val;
    logic [VALUE_WIDTH-1:0] end_val;
  } cfg_t;

  typedef struct packed {
    logic          clamped;
    logic [UW-1:0] u;
  } item_t;

  function automatic logic [UW-1:0] q_mul(input logic [UW-1:0] a, input logic [UW-1:0] b);
    logic [2*UW-1:0] prod;
    prod = a * b + (2*UW)'(HALF_Q);
    return UW'(prod >> FRACTION_BITS);
  endfunction

endpackage

@@ rtl/polynomial_easing.sv @@
// Polynomial easing unit: quad to quint curves in the in, out and in-out forms.
// Configuration writes go over a valid/ready channel; ready is always high and
// a write takes effect at the edge where valid is seen. Write only while the
// block is idle. An input request carries an elapsed time in ticks and is
// taken when in_valid_i is high and in_stall_o is low. Each request produces
// exactly one result request carrying the eased value and the clamp flag.
// The block takes one request per cycle while in_stall_o is low; the front
// normalizes time with a divider that resolves one quotient bit per stage, and
// the back forms the power with one multiplier per stage, then scales by the
// value span.
// A four-entry queue sits between the two halves so each side stalls on its
// own. When out_stall_i is high the back pipeline holds its result; once the
// queue fills the front holds too and in_stall_o rises.
// Reset empties both pipelines and the queue and loads power 2, ease in,
// duration 1 and start and end values of zero.
module polynomial_easing (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pe_pkg::TIME_WIDTH-1:0]  elapsed_ticks_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pe_pkg::VALUE_WIDTH-1:0] eased_value_o,
  output logic                           time_clamped_o
);

  localparam int TW = pe_pkg::TIME_WIDTH;
  localparam int VW = pe_pkg::VALUE_WIDTH;

  pe_pkg::cfg_t  cfg_q;
  logic          front_en, back_en;
  logic          front_valid;
  pe_pkg::item_t front_item, queue_item;
  logic          q_full, q_empty, q_push, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power     <= 3'd2;
      cfg_q.direction <= pe_pkg::DIR_IN;
      cfg_q.duration  <= TW'(1);
      cfg_q.start_val <= '0;
      cfg_q.end_val   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pe_pkg::REG_POWER:     cfg_q.power     <= cfg_data_i[2:0];
        pe_pkg::REG_DIRECTION: cfg_q.direction <= cfg_data_i[1:0];
        pe_pkg::REG_DURATION:  cfg_q.duration  <= cfg_data_i[TW-1:0];
        pe_pkg::REG_START:     cfg_q.start_val <= cfg_data_i[VW-1:0];
        pe_pkg::REG_END:       cfg_q.end_val   <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  assign front_en   = !(front_valid && q_full);
  assign in_stall_o = !front_en;
  assign q_push     = front_valid && !q_full;
  assign back_en    = !(out_valid_o && out_stall_i);
  assign q_pop      = back_en && !q_empty;

  pe_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (front_en),
    .in_take_i       (in_valid_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .duration_i      (cfg_q.duration),
    .valid_o         (front_valid),
    .item_o          (front_item)
  );

  pe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (front_item),
    .pop_i   (q_pop),
    .rdata_o (queue_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (back_en),
    .take_i         (!q_empty),
    .item_i         (queue_item),
    .cfg_i          (cfg_q),
    .valid_o        (out_valid_o),
    .eased_value_o  (eased_value_o),
    .time_clamped_o (time_clamped_o)
  );

endmodule

@@ rtl/pe_front.sv @@
module pe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_take_i,
  input  logic [pe_pkg::TIME_WIDTH-1:0] elapsed_ticks_i,
  input  logic [pe_pkg::TIME_WIDTH-1:0] duration_i,
  output logic                          valid_o,
  output pe_pkg::item_t                 item_o
);

  localparam int TW = pe_pkg::TIME_WIDTH;
  localparam int UW = pe_pkg::UW;
  localparam int NW = pe_pkg::NW;
  localparam int F  = pe_pkg::FRACTION_BITS;

  logic [TW-1:0] dur;
  logic [TW-1:0] t_clamp;
  logic          over;
  logic [NW-1:0] dividend;

  logic          v_q   [0:UW];
  logic          cl_q  [0:UW];
  logic [TW-1:0] rem_q [0:UW];
  logic [UW-1:0] sh_q  [0:UW];

  always_comb begin
    dur      = (duration_i == '0) ? TW'(1) : duration_i;
    over     = elapsed_ticks_i > dur;
    t_clamp  = over ? dur : elapsed_ticks_i;
    dividend = {1'b0, t_clamp, {F{1'b0}}} + NW'(dur >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= in_take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cl_q[0]  <= over;
      rem_q[0] <= dividend[NW-1:UW];
      sh_q[0]  <= dividend[UW-1:0];
    end
  end

  for (genvar k = 0; k < UW; k++) begin : g_div
    logic [TW:0]   rs;
    logic          ge;
    logic [TW:0]   diff;

    always_comb begin
      rs   = {rem_q[k], sh_q[k][UW-1]};
      ge   = rs >= {1'b0, dur};
      diff = rs - {1'b0, dur};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cl_q[k+1]  <= cl_q[k];
        rem_q[k+1] <= ge ? diff[TW-1:0] : rs[TW-1:0];
        sh_q[k+1]  <= {sh_q[k][UW-2:0], ge};
      end
    end
  end

  assign valid_o        = v_q[UW];
  assign item_o.clamped = cl_q[UW];
  assign item_o.u       = sh_q[UW];

endmodule

@@ rtl/pe_queue.sv @@
module pe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pe_pkg::item_t wdata_i,
  input  logic          pop_i,
  output pe_pkg::item_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  pe_pkg::item_t mem_q [0:DEPTH-1];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/pe_back.sv @@
module pe_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           take_i,
  input  pe_pkg::item_t                  item_i,
  input  pe_pkg::cfg_t                   cfg_i,
  output logic                           valid_o,
  output logic [pe_pkg::VALUE_WIDTH-1:0] eased_value_o,
  output logic                           time_clamped_o
);

  localparam int UW = pe_pkg::UW;
  localparam int VW = pe_pkg::VALUE_WIDTH;
  localparam int PW = pe_pkg::PW;
  localparam int F  = pe_pkg::FRACTION_BITS;
  localparam int MS = 4;

  logic [2:0]       pw;
  pe_pkg::mode_e    mode_d;
  logic [UW-1:0]    x_d;
  logic [UW:0]      half_r;
  logic [UW-1:0]    f_d;
  logic [PW-1:0]    prod_d;
  logic [PW-1:0]    q_shift;

  logic             mv_q   [0:MS];
  logic             mcl_q  [0:MS];
  pe_pkg::mode_e    mmode_q[0:MS];
  logic [UW-1:0]    mx_q   [0:MS];
  logic [UW-1:0]    mr_q   [0:MS];

  logic             fv_q, fcl_q;
  logic [UW-1:0]    f_q;
  logic [VW:0]      delta_q;
  logic             pv_q, pcl_q;
  logic [PW-1:0]    prod_q;
  logic             ov_q, ocl_q;
  logic [VW-1:0]    oval_q;

  always_comb begin
    if (cfg_i.power < 3'd2) begin
      pw = 3'd2;
    end else if (cfg_i.power > 3'd5) begin
      pw = 3'd5;
    end else begin
      pw = cfg_i.power;
    end

    case (cfg_i.direction)
      pe_pkg::DIR_IN: begin
        mode_d = pe_pkg::MODE_IN;
        x_d    = item_i.u;
      end
      pe_pkg::DIR_OUT: begin
        mode_d = pe_pkg::MODE_OUT;
        x_d    = pe_pkg::ONE_Q - item_i.u;
      end
      default: begin
        if (item_i.u < pe_pkg::HALF_Q) begin
          mode_d = pe_pkg::MODE_IO_LO;
          x_d    = item_i.u << 1;
        end else begin
          mode_d = pe_pkg::MODE_IO_HI;
          x_d    = (pe_pkg::ONE_Q - item_i.u) << 1;
        end
      end
    endcase

    half_r = ({1'b0, mr_q[MS]} + (UW+1)'(1)) >> 1;
    case (mmode_q[MS])
      pe_pkg::MODE_IN:    f_d = mr_q[MS];
      pe_pkg::MODE_OUT:   f_d = pe_pkg::ONE_Q - mr_q[MS];
      pe_pkg::MODE_IO_LO: f_d = half_r[UW-1:0];
      default:            f_d = pe_pkg::ONE_Q - half_r[UW-1:0];
    endcase

    prod_d  = $signed(PW'($signed(delta_q))) * $signed(PW'({1'b0, f_q}))
              + PW'(pe_pkg::HALF_Q);
    q_shift = $signed(prod_q) >>> F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
      fv_q    <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else if (en_i) begin
      mv_q[0] <= take_i;
      fv_q    <= mv_q[MS];
      pv_q    <= fv_q;
      ov_q    <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mcl_q[0]   <= item_i.clamped;
      mmode_q[0] <= mode_d;
      mx_q[0]    <= x_d;
      mr_q[0]    <= x_d;
      fcl_q      <= mcl_q[MS];
      f_q        <= f_d;
      delta_q    <= {cfg_i.end_val[VW-1], cfg_i.end_val}
                    - {cfg_i.start_val[VW-1], cfg_i.start_val};
      pcl_q      <= fcl_q;
      prod_q     <= prod_d;
      ocl_q      <= pcl_q;
      oval_q     <= cfg_i.start_val + q_shift[VW-1:0];
    end
  end

  for (genvar i = 1; i <= MS; i++) begin : g_mul
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[i] <= 1'b0;
      end else if (en_i) begin
        mv_q[i] <= mv_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mcl_q[i]   <= mcl_q[i-1];
        mmode_q[i] <= mmode_q[i-1];
        mx_q[i]    <= mx_q[i-1];
        mr_q[i]    <= (3'(i) < pw) ? pe_pkg::q_mul(mr_q[i-1], mx_q[i-1]) : mr_q[i-1];
      end
    end
  end

  assign valid_o        = ov_q;
  assign eased_value_o  = oval_q;
  assign time_clamped_o = ocl_q;

endmodule

@@ sim/tb_polynomial_easing.sv @@
`timescale 1ns / 100ps

module tb_polynomial_easing;

  localparam int PIPE_LATENCY = 26;
  localparam int TW = pe_pkg::TIME_WIDTH;
  localparam int VW = pe_pkg::VALUE_WIDTH;
  localparam int FB = pe_pkg::FRACTION_BITS;
  localparam int DW = pe_pkg::CFG_DATA_W;
  localparam int QONE = 1 << FB;
  localparam int QHALF = 1 << (FB - 1);

  typedef struct {
    logic signed [VW-1:0] value;
    logic clamped;
  } eased_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [pe_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [DW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [TW-1:0] elapsed_ticks_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [VW-1:0] eased_value_o;
  logic time_clamped_o;

  logic [2:0] power_q;
  logic [1:0] direction_q;
  logic [TW-1:0] duration_q;
  logic [VW-1:0] start_q;
  logic [VW-1:0] end_q;

  logic [TW-1:0] pending_ticks[$];
  eased_t expected_values[$];
  int mismatches;
  bit quiet_phase;
  bit driver_enable;

  polynomial_easing uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
    return (a * b + QHALF) >> FB;
  endfunction

  function automatic longint unsigned fix_pow(longint unsigned x, int p);
    longint unsigned r;
    r = x;
    for (int i = 1; i < p; i++) r = fix_mul(r, x);
    return r;
  endfunction

  function automatic eased_t ease_predict(logic [TW-1:0] ticks);
    eased_t res;
    longint unsigned t, d, u, f, w;
    longint s, span, prod, q;
    int p;
    t = ticks;
    d = (duration_q == 0) ? 1 : duration_q;
    p = power_q;
    if (p < 2) p = 2;
    if (p > 5) p = 5;
    res.clamped = 1'b0;
    if (t > d) begin
      t = d;
      res.clamped = 1'b1;
    end
    u = ((t << FB) + (d >> 1)) / d;
    if (u > QONE) u = QONE;
    if (direction_q == pe_pkg::DIR_IN) begin
      f = fix_pow(u, p);
    end else if (direction_q == pe_pkg::DIR_OUT) begin
      f = QONE - fix_pow(QONE - u, p);
    end else if (u < QHALF) begin
      w = u << 1;
      f = (fix_pow(w, p) + 1) >> 1;
    end else begin
      w = (QONE - u) << 1;
      f = QONE - ((fix_pow(w, p) + 1) >> 1);
    end
    s = longint'($signed(start_q));
    span = longint'($signed(end_q)) - s;
    prod = span * longint'(f) + QHALF;
    if (prod >= 0) q = prod >>> FB;
    else q = -((-prod + QONE - 1) >>> FB);
    res.value = VW'(s + q);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      elapsed_ticks_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_values.push_back(ease_predict(elapsed_ticks_i));
        void'(pending_ticks.pop_front());
      end
      if ((!in_valid_i || !in_stall_o) && driver_enable) begin
        if (pending_ticks.size() > 0 && (quiet_phase || $urandom_range(99) >= 14)) begin
          in_valid_i <= 1'b1;
          elapsed_ticks_i <= pending_ticks[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!driver_enable) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    eased_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch("unexpected result", $signed(eased_value_o), 0);
        end else begin
          want = expected_values.pop_front();
          if (eased_value_o !== want.value)
            report_mismatch("eased_value", $signed(eased_value_o), want.value);
          if (time_clamped_o !== want.clamped)
            report_mismatch("time_clamped", time_clamped_o, want.clamped);
        end
      end
      out_stall_i <= quiet_phase ? 1'b0 : ($urandom_range(99) < 14);
    end
  end

  task automatic write_reg(pe_pkg::cfg_reg_e idx, logic [DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pe_pkg::REG_POWER: power_q = data[2:0];
      pe_pkg::REG_DIRECTION: direction_q = data[1:0];
      pe_pkg::REG_DURATION: duration_q = data[TW-1:0];
      pe_pkg::REG_START: start_q = data[VW-1:0];
      pe_pkg::REG_END: end_q = data[VW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int n, bit directed);
    logic [TW-1:0] d;
    d = (duration_q == '0) ? TW'(1) : duration_q;
    if (directed) begin
      pending_ticks.push_back('0);
      pending_ticks.push_back(d);
      pending_ticks.push_back(d >> 1);
      pending_ticks.push_back((d >> 1) + TW'(1));
      pending_ticks.push_back(16'hFFFF);
      pending_ticks.push_back(16'h5555);
      pending_ticks.push_back(16'hAAAA);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) pending_ticks.push_back(TW'($urandom_range(d)));
      else pending_ticks.push_back(TW'($urandom()));
    end
    driver_enable = 1'b1;
    wait (pending_ticks.size() == 0 && !(in_valid_i && in_stall_o));
    @(posedge clk_i);
    driver_enable = 1'b0;
    wait (expected_values.size() == 0);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  initial begin
    logic [DW-1:0] dur, sv, ev;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    mismatches = 0;
    quiet_phase = 1'b0;
    driver_enable = 1'b0;
    power_q = 3'd2;
    direction_q = pe_pkg::DIR_IN;
    duration_q = TW'(1);
    start_q = '0;
    end_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(4, 1'b1);
    write_reg(pe_pkg::REG_DURATION, '0);
    write_reg(pe_pkg::REG_START, 24'h800000);
    write_reg(pe_pkg::REG_END, 24'h7FFFFF);
    run_phase(4, 1'b1);
    for (int ph = 0; ph < 40; ph++) begin
      case (ph % 5)
        0: dur = DW'(16'hFFFF);
        1: dur = DW'(1);
        default: dur = DW'($urandom_range(1, (ph % 5 == 2) ? 200 : 65535));
      endcase
      case (ph % 4)
        0: begin sv = 24'h800000; ev = 24'h7FFFFF; end
        1: begin sv = 24'h7FFFFF; ev = 24'h800000; end
        default: begin sv = DW'($urandom()); ev = DW'($urandom()); end
      endcase
      write_reg(pe_pkg::REG_POWER, (ph < 8) ? DW'(ph) : DW'($urandom_range(7)));
      write_reg(pe_pkg::REG_DIRECTION, DW'(ph % 4));
      write_reg(pe_pkg::REG_DURATION, dur);
      write_reg(pe_pkg::REG_START, sv);
      write_reg(pe_pkg::REG_END, ev);
      quiet_phase = (ph == 20);
      run_phase(30, ph < 8);
    end
    if (mismatches == 0) begin
      $display("polynomial_easing regression: pass");
    end else begin
      $display("polynomial_easing regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("polynomial_easing regression: fail");
    $finish;
  end

endmodule
